// ===== rtl/bmg_pkg.sv =====
// bmg_pkg: constants, types and the output scaling function of the gaussian generator.
// Used by box_muller_gaussian; depends on nothing.
package bmg_pkg;

   localparam int unsigned UNIFORM_BITS  = 32;
   localparam int unsigned OUT_FRAC_BITS = 16;
   localparam int unsigned OUT_WIDTH     = 20;

   localparam logic [55:0] LN2_Q56    = 56'hB17217F7D1CF7A;
   localparam logic [63:0] HALFPI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] ONE_Q62    = 64'h4000000000000000;

   // pipeline shape
   localparam int unsigned DIV_STAGES  = 16;
   localparam int unsigned LOG_TERMS   = 21;
   localparam int unsigned TRIG_GROUPS = 10;
   localparam int unsigned SQRT_STAGES = 16;
   localparam int unsigned ANG_DELAY   = 33;
   localparam int unsigned LATENCY     = 103;

   // quadrant codes: top two bits of the phase
   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   typedef struct packed {
      logic [5:0]  p;
      logic [63:0] s2;
      logic [63:0] sum;
   } log_type;

   typedef struct packed {
      logic [63:0] a;
      logic [1:0]  quad;
      logic        swap;
   } ang_type;

   typedef struct packed {
      logic [63:0] a2;
      logic [63:0] s_term;
      logic [63:0] c_term;
      logic [63:0] s_acc;
      logic [63:0] c_acc;
      logic [1:0]  quad;
      logic        swap;
   } trig_type;

   typedef struct packed {
      logic [30:0] cm;
      logic        cn;
      logic [30:0] sm;
      logic        sn;
   } trig_out_type;

   typedef struct packed {
      logic vld;
      logic single;
   } tag_type;

   // round half up to the output grid, saturate, apply the sign
   function automatic logic [OUT_WIDTH-1:0] scale_out(input logic [63:0] prod,
                                                     input logic neg);
      logic [63:0] mag;
      logic [63:0] lim;
      mag = (prod + (64'd1 << (58 - OUT_FRAC_BITS - 1))) >> (58 - OUT_FRAC_BITS);
      lim = 64'd1 << (OUT_WIDTH - 1);
      if (!neg) begin
         if (mag > lim - 64'd1) mag = lim - 64'd1;
         return mag[OUT_WIDTH-1:0];
      end
      if (mag > lim) mag = lim;
      return OUT_WIDTH'(64'd0 - mag);
   endfunction

endpackage

// ===== rtl/box_muller_gaussian.sv =====
// box_muller_gaussian: fixed-point Box-Muller gaussian pair generator, fully pipelined.
// Depends on bmg_pkg and bmg_mul64.
//
// Takes one pair of 32-bit uniform codes every clock (busy is always low) and returns
// r*cos and r*sin with 16 fraction bits, one rsp_strobe pulse per start beat, in order.
// The radius path sets the delay: a 62-bit quotient at four bits per stage (two in the
// last stage), a 21-term atanh series at three stages per term and a 32-step square root
// at two steps per stage; the angle path is shorter and waits in a delay line. Results
// cannot be held off: take them in the strobe cycle.
module box_muller_gaussian (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [31:0]         req_u_radius,
   input  logic [31:0]         req_u_angle,
   input  logic                req_single_only,
   output logic                rsp_strobe,
   output logic signed [19:0]  rsp_z_cos,
   output logic signed [19:0]  rsp_z_sin,
   output logic                rsp_sin_valid
);

   assign busy = 1'b0;

   // ---------------- beat tags ----------------
   bmg_pkg::tag_type tg_ff [1:bmg_pkg::LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= int'(bmg_pkg::LATENCY); i++) tg_ff[i] <= '0;
      end else begin
         tg_ff[1] <= '{vld: start && !busy, single: req_single_only};
         for (int i = 2; i <= int'(bmg_pkg::LATENCY); i++) tg_ff[i] <= tg_ff[i-1];
      end
   end

   // ---------------- radius: s = (2^p - m)/(2^p + m) ----------------
   logic [34:0] dv_rem_ff [0:bmg_pkg::DIV_STAGES];
   logic [34:0] dv_den_ff [0:bmg_pkg::DIV_STAGES];
   logic [61:0] dv_q_ff   [0:bmg_pkg::DIV_STAGES];
   logic [5:0]  dv_p_ff   [0:bmg_pkg::DIV_STAGES];

   logic [5:0]  p_in;
   logic [32:0] m_in;
   logic [33:0] pow_in;

   always_comb begin
      p_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (req_u_radius[i]) p_in = 6'(i + 1);
      end
      m_in   = {1'b0, req_u_radius} + 33'd1;
      pow_in = 34'd1 << p_in;
   end

   always_ff @(posedge clock) begin
      dv_rem_ff[0] <= 35'(pow_in - {1'b0, m_in});
      dv_den_ff[0] <= 35'(pow_in) + 35'(m_in);
      dv_q_ff[0]   <= '0;
      dv_p_ff[0]   <= p_in;
   end

   for (genvar j = 0; j < bmg_pkg::DIV_STAGES; j++) begin : g_div
      localparam int NS = (j == bmg_pkg::DIV_STAGES - 1) ? 2 : 4;
      logic [34:0] rem_v;
      logic [61:0] q_v;
      always_comb begin
         rem_v = dv_rem_ff[j];
         q_v   = dv_q_ff[j];
         for (int i = 0; i < NS; i++) begin
            rem_v = {rem_v[33:0], 1'b0};
            q_v   = {q_v[60:0], 1'b0};
            if (rem_v >= dv_den_ff[j]) begin
               rem_v = rem_v - dv_den_ff[j];
               q_v[0] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         dv_rem_ff[j+1] <= rem_v;
         dv_den_ff[j+1] <= dv_den_ff[j];
         dv_q_ff[j+1]   <= q_v;
         dv_p_ff[j+1]   <= dv_p_ff[j];
      end
   end

   // ---------------- s squared ----------------
   logic [127:0] s2_prod;
   logic [61:0]  sd1_s_ff, sd2_s_ff;
   logic [5:0]   sd1_p_ff, sd2_p_ff;

   bmg_mul64 u_s2 (
      .clock (clock),
      .a     ({2'b00, dv_q_ff[bmg_pkg::DIV_STAGES]}),
      .b     ({2'b00, dv_q_ff[bmg_pkg::DIV_STAGES]}),
      .prod  (s2_prod)
   );

   always_ff @(posedge clock) begin
      sd1_s_ff <= dv_q_ff[bmg_pkg::DIV_STAGES];
      sd1_p_ff <= dv_p_ff[bmg_pkg::DIV_STAGES];
      sd2_s_ff <= sd1_s_ff;
      sd2_p_ff <= sd1_p_ff;
   end

   // ---------------- atanh series ----------------
   bmg_pkg::log_type lg_ff    [0:bmg_pkg::LOG_TERMS];
   logic [63:0]      lg_pw_ff [0:bmg_pkg::LOG_TERMS-1];

   always_ff @(posedge clock) begin
      lg_ff[0]    <= '{p: sd2_p_ff, s2: s2_prod[125:62], sum: 64'd0};
      lg_pw_ff[0] <= {2'b00, sd2_s_ff};
   end

   for (genvar g = 0; g < bmg_pkg::LOG_TERMS; g++) begin : g_log
      localparam int unsigned DIVISOR = 2 * g + 1;
      localparam int unsigned SHIFT   = $clog2(DIVISOR);
      localparam logic [127:0] SCALE  = 128'd1 << (62 + SHIFT);
      localparam logic [63:0] RECIP   = 64'((SCALE + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR));
      logic [127:0]     quo_prod;
      bmg_pkg::log_type side1_ff, side2_ff;

      bmg_mul64 u_quo (.clock(clock), .a(lg_pw_ff[g]), .b(RECIP), .prod(quo_prod));

      always_ff @(posedge clock) begin
         side1_ff <= lg_ff[g];
         side2_ff <= side1_ff;
         lg_ff[g+1] <= '{p: side2_ff.p, s2: side2_ff.s2,
                         sum: side2_ff.sum + 64'(quo_prod >> (62 + SHIFT))};
      end

      if (g < bmg_pkg::LOG_TERMS - 1) begin : g_pow
         logic [127:0] pow_prod;
         bmg_mul64 u_pow (.clock(clock), .a(lg_pw_ff[g]), .b(lg_ff[g].s2), .prod(pow_prod));
         always_ff @(posedge clock) begin
            lg_pw_ff[g+1] <= pow_prod[125:62];
         end
      end
   end

   // ---------------- -ln u1 in Q.56, doubled to t = -2 ln u1 at the root input ----------------
   logic [57:0] tl_lng_ff;
   logic [62:0] tl_lnp_ff;
   logic [6:0]  oct_v;

   assign oct_v = 7'(bmg_pkg::UNIFORM_BITS) - {1'b0, lg_ff[bmg_pkg::LOG_TERMS].p};

   always_ff @(posedge clock) begin
      tl_lng_ff <= 58'(({lg_ff[bmg_pkg::LOG_TERMS].sum[62:0], 1'b0} + 64'd32) >> 6);
      tl_lnp_ff <= 63'(oct_v) * 63'(bmg_pkg::LN2_Q56);
   end

   // ---------------- integer square root, two steps per stage ----------------
   logic [63:0] sq_x_ff [0:bmg_pkg::SQRT_STAGES];
   logic [63:0] sq_r_ff [0:bmg_pkg::SQRT_STAGES];

   always_ff @(posedge clock) begin
      sq_x_ff[0] <= {tl_lnp_ff + 63'(tl_lng_ff), 1'b0};
      sq_r_ff[0] <= '0;
   end

   for (genvar j = 0; j < bmg_pkg::SQRT_STAGES; j++) begin : g_sqrt
      logic [63:0] x_v, r_v, bit_v;
      always_comb begin
         x_v = sq_x_ff[j];
         r_v = sq_r_ff[j];
         bit_v = '0;
         for (int b = 0; b < 2; b++) begin
            bit_v = 64'd1 << (62 - 2 * (2 * j + b));
            if (x_v >= r_v + bit_v) begin
               x_v = x_v - (r_v + bit_v);
               r_v = (r_v >> 1) + bit_v;
            end else begin
               r_v = r_v >> 1;
            end
         end
      end
      always_ff @(posedge clock) begin
         sq_x_ff[j+1] <= x_v;
         sq_r_ff[j+1] <= r_v;
      end
   end

   // ---------------- angle: reduce to the first octant ----------------
   logic [29:0] ax_ff;
   logic [1:0]  aq1_ff, aq2_ff, aq3_ff;
   logic        as1_ff, as2_ff, as3_ff;
   logic [29:0] x_in;
   logic        swap_in;

   assign x_in    = req_u_angle[29:0];
   assign swap_in = x_in > 30'h20000000;

   always_ff @(posedge clock) begin
      ax_ff  <= swap_in ? 30'(31'h40000000 - 31'(x_in)) : x_in;
      aq1_ff <= req_u_angle[31:30];
      as1_ff <= swap_in;
      aq2_ff <= aq1_ff;
      as2_ff <= as1_ff;
      aq3_ff <= aq2_ff;
      as3_ff <= as2_ff;
   end

   logic [127:0]     a_prod, a2_prod;
   bmg_pkg::ang_type ag_ff, ag1_ff, ag2_ff;

   bmg_mul64 u_ang (.clock(clock), .a(64'(ax_ff)), .b(bmg_pkg::HALFPI_Q62), .prod(a_prod));
   bmg_mul64 u_asq (.clock(clock), .a(ag_ff.a), .b(ag_ff.a), .prod(a2_prod));

   bmg_pkg::trig_type tr_ff [0:bmg_pkg::TRIG_GROUPS];

   always_ff @(posedge clock) begin
      ag_ff  <= '{a: a_prod[93:30], quad: aq3_ff, swap: as3_ff};
      ag1_ff <= ag_ff;
      ag2_ff <= ag1_ff;
      tr_ff[0] <= '{a2: a2_prod[125:62], s_term: ag2_ff.a, c_term: bmg_pkg::ONE_Q62,
                    s_acc: ag2_ff.a, c_acc: bmg_pkg::ONE_Q62,
                    quad: ag2_ff.quad, swap: ag2_ff.swap};
   end

   // ---------------- sine and cosine series, one term of each per group, cosine only in the last ----------------
   for (genvar j = 0; j < bmg_pkg::TRIG_GROUPS; j++) begin : g_trig
      localparam int unsigned C_DIV   = (2 * j + 1) * (2 * j + 2);
      localparam int unsigned S_DIV   = (2 * j + 2) * (2 * j + 3);
      localparam int unsigned C_SHIFT = $clog2(C_DIV);
      localparam int unsigned S_SHIFT = $clog2(S_DIV);
      localparam logic [127:0] C_SCALE = 128'd1 << (62 + C_SHIFT);
      localparam logic [127:0] S_SCALE = 128'd1 << (62 + S_SHIFT);
      localparam logic [63:0] C_RECIP = 64'((C_SCALE + 128'(C_DIV) - 128'd1) / 128'(C_DIV));
      localparam logic [63:0] S_RECIP = 64'((S_SCALE + 128'(S_DIV) - 128'd1) / 128'(S_DIV));
      localparam bit SUB    = (j % 2) == 0;
      localparam bit S_LIVE = j < bmg_pkg::TRIG_GROUPS - 1;

      logic [127:0]      s_sq_prod, c_sq_prod, s_dv_prod, c_dv_prod;
      bmg_pkg::trig_type tr1_ff, tr2_ff, tm_ff, tm1_ff, tm2_ff;
      logic [63:0]       s_q, c_q;

      bmg_mul64 u_s_sq (.clock(clock), .a(tr_ff[j].s_term), .b(tr_ff[j].a2), .prod(s_sq_prod));
      bmg_mul64 u_c_sq (.clock(clock), .a(tr_ff[j].c_term), .b(tr_ff[j].a2), .prod(c_sq_prod));
      bmg_mul64 u_s_dv (.clock(clock), .a(tm_ff.s_term), .b(S_RECIP), .prod(s_dv_prod));
      bmg_mul64 u_c_dv (.clock(clock), .a(tm_ff.c_term), .b(C_RECIP), .prod(c_dv_prod));

      assign s_q = 64'(s_dv_prod >> (62 + S_SHIFT));
      assign c_q = 64'(c_dv_prod >> (62 + C_SHIFT));

      always_ff @(posedge clock) begin
         tr1_ff <= tr_ff[j];
         tr2_ff <= tr1_ff;
         tm_ff  <= '{a2: tr2_ff.a2, s_term: s_sq_prod[125:62], c_term: c_sq_prod[125:62],
                     s_acc: tr2_ff.s_acc, c_acc: tr2_ff.c_acc,
                     quad: tr2_ff.quad, swap: tr2_ff.swap};
         tm1_ff <= tm_ff;
         tm2_ff <= tm1_ff;
         tr_ff[j+1] <= '{a2: tm2_ff.a2, s_term: s_q, c_term: c_q,
                         s_acc: !S_LIVE ? tm2_ff.s_acc :
                                SUB ? tm2_ff.s_acc - s_q : tm2_ff.s_acc + s_q,
                         c_acc: SUB ? tm2_ff.c_acc - c_q : tm2_ff.c_acc + c_q,
                         quad: tm2_ff.quad, swap: tm2_ff.swap};
      end
   end

   // ---------------- round to Q.30, undo the octant fold, quadrant signs ----------------
   bmg_pkg::trig_out_type ad_ff [0:bmg_pkg::ANG_DELAY];
   bmg_pkg::trig_out_type rd_in;
   logic [30:0]           c30, s30, cf, sf;

   always_comb begin
      c30 = 31'((tr_ff[bmg_pkg::TRIG_GROUPS].c_acc + 64'h80000000) >> 32);
      s30 = 31'((tr_ff[bmg_pkg::TRIG_GROUPS].s_acc + 64'h80000000) >> 32);
      cf  = tr_ff[bmg_pkg::TRIG_GROUPS].swap ? s30 : c30;
      sf  = tr_ff[bmg_pkg::TRIG_GROUPS].swap ? c30 : s30;
      case (tr_ff[bmg_pkg::TRIG_GROUPS].quad)
         bmg_pkg::QUAD_I:   rd_in = '{cm: cf, cn: 1'b0, sm: sf, sn: 1'b0};
         bmg_pkg::QUAD_II:  rd_in = '{cm: sf, cn: 1'b1, sm: cf, sn: 1'b0};
         bmg_pkg::QUAD_III: rd_in = '{cm: cf, cn: 1'b1, sm: sf, sn: 1'b1};
         default:           rd_in = '{cm: sf, cn: 1'b0, sm: cf, sn: 1'b1};
      endcase
   end

   // wait for the radius path
   always_ff @(posedge clock) begin
      ad_ff[0] <= rd_in;
      for (int i = 1; i <= int'(bmg_pkg::ANG_DELAY); i++) ad_ff[i] <= ad_ff[i-1];
   end

   // ---------------- r * trig, round, saturate, zero the sine of a single-only beat ----------------
   logic [63:0] pc_cos_ff, pc_sin_ff;
   logic        pn_cos_ff, pn_sin_ff;
   logic [19:0] zc_ff, zs_ff;
   logic        sv_ff;

   always_ff @(posedge clock) begin
      pc_cos_ff <= 64'(sq_r_ff[bmg_pkg::SQRT_STAGES][31:0]) * 64'(ad_ff[bmg_pkg::ANG_DELAY].cm);
      pc_sin_ff <= 64'(sq_r_ff[bmg_pkg::SQRT_STAGES][31:0]) * 64'(ad_ff[bmg_pkg::ANG_DELAY].sm);
      pn_cos_ff <= ad_ff[bmg_pkg::ANG_DELAY].cn;
      pn_sin_ff <= ad_ff[bmg_pkg::ANG_DELAY].sn;
      zc_ff <= bmg_pkg::scale_out(pc_cos_ff, pn_cos_ff);
      zs_ff <= tg_ff[bmg_pkg::LATENCY-1].single ? 20'd0
                                                : bmg_pkg::scale_out(pc_sin_ff, pn_sin_ff);
      sv_ff <= !tg_ff[bmg_pkg::LATENCY-1].single;
   end

   assign rsp_strobe    = tg_ff[bmg_pkg::LATENCY].vld;
   assign rsp_z_cos     = signed'(zc_ff);
   assign rsp_z_sin     = signed'(zs_ff);
   assign rsp_sin_valid = sv_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##(bmg_pkg::LATENCY) rsp_strobe)
      else $error("start beat did not produce a result after the pipeline latency");

   a_tail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_sin_valid) |-> (rsp_z_sin == 20'sd0))
      else $error("odd tail beat carries a nonzero sine sample");

   a_trig_range : assert property (@(posedge clock) disable iff (reset)
      tg_ff[68].vld |-> (ad_ff[0].cm <= 31'h40000000 && ad_ff[0].sm <= 31'h40000000))
      else $error("rounded trig magnitude above one");

   a_root_range : assert property (@(posedge clock) disable iff (reset)
      tg_ff[101].vld |-> (sq_r_ff[bmg_pkg::SQRT_STAGES][63:31] == 33'd0))
      else $error("radius root wider than 31 bits");
`endif

endmodule

// ===== rtl/bmg_mul64.sv =====
// bmg_mul64: two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Leaf module, no package dependency; used by box_muller_gaussian.
module bmg_mul64 (
   input  logic          clock,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic [127:0]  prod
);

   logic [63:0]  pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [127:0] prod_ff;

   always_ff @(posedge clock) begin
      pp_ll_ff <= 64'(a[31:0]) * 64'(b[31:0]);
      pp_lh_ff <= 64'(a[31:0]) * 64'(b[63:32]);
      pp_hl_ff <= 64'(a[63:32]) * 64'(b[31:0]);
      pp_hh_ff <= 64'(a[63:32]) * 64'(b[63:32]);
      prod_ff  <= {pp_hh_ff, 64'd0} + ({64'd0, pp_lh_ff} << 32) + ({64'd0, pp_hl_ff} << 32)
                  + {64'd0, pp_ll_ff};
   end

   assign prod = prod_ff;

endmodule
